@@ hw/rtl/ccd_pkg.sv @@
// Shared types, constants and decode helpers for the cheat code text decoder.
package ccd_pkg;

  // Code format, taken from the first character of a code
  typedef enum logic {
    FmtScrambled = 1'b0,
    FmtPlain     = 1'b1
  } ccd_fmt_e;

  // Input word: one character of the code text
  typedef struct packed {
    logic [7:0] code_char;
    logic       req_type;
    logic       last_char;
  } ccd_in_t;

  // Output word: one decoded patch
  typedef struct packed {
    logic [23:0] patch_address;
    logic [7:0]  patch_value;
    logic        decode_status;
  } ccd_out_t;

  localparam int unsigned CntW = 4;

  localparam logic [CntW-1:0] ScrambledLen = CntW'(9);
  localparam logic [CntW-1:0] PlainLen     = CntW'(8);
  localparam logic [CntW-1:0] DashPos      = CntW'(4);
  localparam logic [CntW-1:0] CntMax       = '1;

  localparam logic [7:0] CharDash  = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowF  = 8'h66;

  localparam logic        StatusOk  = 1'b0;
  localparam logic        StatusBad = 1'b1;

  // Position of each hex digit in the substitution alphabet DF4709156BC8A23E,
  // indexed by the digit's value
  localparam logic [3:0] SubstIdx [16] = '{
    4'd4,  4'd6,  4'd13, 4'd14, 4'd2,  4'd7,  4'd8,  4'd3,
    4'd11, 4'd5,  4'd12, 4'd9,  4'd10, 4'd0,  4'd15, 4'd1
  };

  // Hex digit value; bit 4 set for a character that is no hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= CharZero && c <= CharNine) begin
      r = {1'b0, 4'(c - CharZero)};
    end else if (c >= CharLowA && c <= CharLowF) begin
      r = {1'b0, 4'(c - CharLowA + 8'd10)};
    end else if (c >= CharUpA && c <= CharUpF) begin
      r = {1'b0, 4'(c - CharUpA + 8'd10)};
    end
    return r;
  endfunction

  // Scrambled address bit shuffle: the fields under masks 003c00, 00003c,
  // f00000, 000003, 00c000, 0f0000 and 0003c0 move to their new places
  function automatic logic [23:0] permute_address(input logic [23:0] a);
    return {a[13:10], a[5:2], a[23:20], a[1:0], a[15:14], a[19:16], a[9:6]};
  endfunction

endpackage

@@ hw/rtl/cheat_code_text_decoder_top.sv @@
// Cheat code text decoder: character input register, decode, result register.
//
//   channel | handshake          | word
//   --------+--------------------+------------------------------------------
//   in      | in_valid_i/ready_o | in_word_i  : code_char, req_type, last_char
//   out     | out_valid_o/ready_i| out_word_o : patch_address, patch_value,
//           |                    |              decode_status
//
// One character word is taken per cycle while the result side does not stall;
// the last character passes the input register and then the result register.
// The decode of a character sits between those two registers and is one
// nibble lookup plus a shift of the digit accumulator.
// Reset clears the code state and both valid flags.
// A stalled result holds the input register, which then holds the input side.
module cheat_code_text_decoder_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ccd_pkg::ccd_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ccd_pkg::ccd_out_t out_word_o
);
  import ccd_pkg::*;

  logic            in_vld_q;
  ccd_in_t         in_q;
  logic            out_vld_q, out_vld_d;
  ccd_out_t        out_q, out_d;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     acc_q, acc_d;
  logic            bad_q, bad_d;
  ccd_fmt_e        fmt_q, fmt_d;

  logic            fire;
  logic [CntW-1:0] len;
  logic [4:0]      hex;
  logic [3:0]      nib;

  // Advance a held character when the result slot is free or being freed
  assign fire       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || fire;

  // Capture the input word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_word_i;
    end
  end

  // Decode one character and update the code state
  always_comb begin
    fmt_d = (cnt_q == '0) ? ccd_fmt_e'(in_q.req_type) : fmt_q;
    len   = (fmt_d == FmtPlain) ? PlainLen : ScrambledLen;
    hex   = hex_decode(in_q.code_char);
    nib   = (fmt_d == FmtPlain) ? hex[3:0] : SubstIdx[hex[3:0]];
    acc_d = acc_q;
    bad_d = bad_q;
    if (cnt_q >= len) begin
      bad_d = 1'b1;
    end else if (fmt_d == FmtScrambled && cnt_q == DashPos) begin
      if (in_q.code_char != CharDash) begin
        bad_d = 1'b1;
      end
    end else if (hex[4]) begin
      bad_d = 1'b1;
    end else begin
      acc_d = {acc_q[27:0], nib};
    end
    cnt_d = (cnt_q == CntMax) ? cnt_q : cnt_q + 1'b1;

    // Form the result on the last character
    out_d = '0;
    if (bad_d || cnt_d != len) begin
      out_d.decode_status = StatusBad;
    end else if (fmt_d == FmtPlain) begin
      out_d.patch_address = acc_d[31:8];
      out_d.patch_value   = acc_d[7:0];
      out_d.decode_status = StatusOk;
    end else begin
      out_d.patch_address = permute_address(acc_d[23:0]);
      out_d.patch_value   = acc_d[31:24];
      out_d.decode_status = StatusOk;
    end

    out_vld_d = out_vld_q && !out_ready_i;
    if (fire && in_q.last_char) begin
      out_vld_d = 1'b1;
    end
  end

  // Hold code state; clear it after the last character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      acc_q <= '0;
      bad_q <= 1'b0;
      fmt_q <= FmtScrambled;
    end else if (fire) begin
      if (in_q.last_char) begin
        cnt_q <= '0;
        acc_q <= '0;
        bad_q <= 1'b0;
        fmt_q <= FmtScrambled;
      end else begin
        cnt_q <= cnt_d;
        acc_q <= acc_d;
        bad_q <= bad_d;
        fmt_q <= fmt_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && in_q.last_char) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  // A finished code leaves no state behind
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_q.last_char |=> cnt_q == '0 && acc_q == '0 && !bad_q)
    else $error("code state not cleared after last character");

  // An invalid result carries zero address and value
  a_bad_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.decode_status == StatusBad |->
      out_word_o.patch_address == '0 && out_word_o.patch_value == '0)
    else $error("invalid result with nonzero payload");

  // A middle character leaves the count nonzero; the count saturates at its maximum
  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !in_q.last_char |=> cnt_q != '0)
    else $error("character count did not advance");

  // Input side stalls only while a character waits in the input register
  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_vld_q && out_vld_q && !out_ready_i)
    else $error("input stalled without a waiting result");

endmodule
